>>> rtl/core/postfix_stack_evaluator_top_macros.svh
// ============================================================================
// Assertion macros for the postfix stack evaluator
// Shared shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pse_pkg.sv
// ============================================================================
// Postfix stack evaluator package
// Sizes, codes, controller states and the command/status bundles.
// ============================================================================
package pse_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    // Stream sideband widths
    localparam int IN_USER_W   = 5;
    localparam int OUT_USER_W  = 3;

    // Item kinds
    localparam logic [1:0] OPC_PUSH  = 2'd0;
    localparam logic [1:0] OPC_APPLY = 2'd1;
    localparam logic [1:0] OPC_END   = 2'd2;

    // Operators
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_XOR = 3'd4;
    localparam logic [2:0] OP_REM = 3'd5;
    localparam logic [2:0] OP_OR  = 3'd6;
    localparam logic [2:0] OP_AND = 3'd7;

    // Sticky error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_B,
        S_RD_A,
        S_LOAD_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       cap_op;     // latch operator of the accepted item
        logic       push;       // write operand at depth, depth + 1
        logic       flag_en;    // raise sticky error if none yet
        logic [1:0] flag_code;
        logic       rd_en;      // read stack into the read register
        logic       rd_second;  // 0: entry below depth, 1: two below depth
        logic       cap_b;      // right operand from read register
        logic       cap_a;      // left operand from read register
        logic       exec;       // result from the single-cycle ALU
        logic       div_start;
        logic       div_cap;    // result from the divider
        logic       wr_res;     // write result two below depth, depth - 1
        logic       out_load;   // load output register with the top entry
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic lt2;
        logic depth_zero;
        logic last_entry;
        logic err_zero;
        logic div_op;
        logic b_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/pse_div.sv
// ============================================================================
// Signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// sign fix applied on the outputs. Truncates toward zero.
// ============================================================================
module pse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pse_pkg::DATA_W-1:0] i_dividend,
    input  logic [pse_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pse_pkg::DATA_W-1:0] o_quotient,
    output logic [pse_pkg::DATA_W-1:0] o_remainder
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic              r_neg_q;
    logic              r_neg_r;

    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;

    // Magnitudes of the operands
    assign w_mag_a = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
    assign w_mag_b = i_divisor[DATA_W-1]  ? (~i_divisor  + DATA_W'(1)) : i_divisor;

    // One restoring step
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= w_mag_a;
            r_rem   <= '0;
            r_den   <= w_mag_b;
            r_neg_q <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_neg_r <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // Restore signs
    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (~r_quo + DATA_W'(1)) : r_quo;
    assign o_remainder = r_neg_r ? (~r_rem + DATA_W'(1)) : r_rem;

endmodule

>>> rtl/core/pse_datapath.sv
// ============================================================================
// Postfix stack evaluator datapath
// Stack memory, depth and sticky error, operand registers, ALU, divider
// and the output register.
// ============================================================================
module pse_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pse_pkg::t_cmd                i_cmd,
    output pse_pkg::t_status             o_status,
    input  logic [pse_pkg::DATA_W-1:0]   i_operand,
    input  logic [2:0]                   i_operator,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pse_pkg::DATA_W-1:0]   o_value,
    output logic                         o_stack_empty,
    output logic [1:0]                   o_error_code,
    output logic                         o_last
);
    import pse_pkg::*;

    logic [DATA_W-1:0]  r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  r_rdata;
    logic [DEPTH_W-1:0] r_depth;
    logic [1:0]         r_err;
    logic [2:0]         r_op;
    logic [DATA_W-1:0]  r_a;
    logic [DATA_W-1:0]  r_b;
    logic [DATA_W-1:0]  r_res;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic               r_out_empty;
    logic [1:0]         r_out_err;
    logic               r_out_last;

    logic [DEPTH_W-1:0] w_dm1;
    logic [DEPTH_W-1:0] w_dm2;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [DATA_W-1:0]  w_wr_data;
    logic               w_wr_en;
    logic [DATA_W-1:0]  w_alu;
    logic               w_div_done;
    logic [DATA_W-1:0]  w_quo;
    logic [DATA_W-1:0]  w_rem;

    assign w_dm1 = r_depth - DEPTH_W'(1);
    assign w_dm2 = r_depth - DEPTH_W'(2);

    // Stack port addressing
    assign w_rd_addr = i_cmd.rd_second ? w_dm2[IDX_W-1:0] : w_dm1[IDX_W-1:0];
    assign w_wr_en   = i_cmd.push || i_cmd.wr_res;
    assign w_wr_addr = i_cmd.push ? r_depth[IDX_W-1:0] : w_dm2[IDX_W-1:0];
    assign w_wr_data = i_cmd.push ? i_operand : r_res;

    // Stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Depth and sticky error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= ERR_NONE;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.wr_res) begin
                r_depth <= w_dm1;
            end else if (i_cmd.out_load && (r_depth != '0)) begin
                r_depth <= w_dm1;
            end
            if (i_cmd.out_load && (r_depth <= DEPTH_W'(1))) begin
                r_err <= ERR_NONE;
            end else if (i_cmd.flag_en && (r_err == ERR_NONE)) begin
                r_err <= i_cmd.flag_code;
            end
        end
    end

    // Single-cycle operations; divide and remainder here only for a zero divisor
    always_comb begin
        unique case (r_op)
            OP_ADD:  w_alu = r_a + r_b;
            OP_SUB:  w_alu = r_a - r_b;
            OP_MUL:  w_alu = r_a * r_b;
            OP_DIV:  w_alu = '0;
            OP_XOR:  w_alu = r_a ^ r_b;
            OP_REM:  w_alu = '0;
            OP_OR:   w_alu = r_a | r_b;
            OP_AND:  w_alu = r_a & r_b;
            default: w_alu = '0;
        endcase
    end

    pse_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_a),
        .i_divisor   (r_b),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Operator, operands and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_op) begin
            r_op <= i_operator;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rdata;
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rdata;
        end
        if (i_cmd.exec) begin
            r_res <= w_alu;
        end else if (i_cmd.div_cap) begin
            r_res <= (r_op == OP_REM) ? w_rem : w_quo;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= (r_depth == '0) ? '0 : r_rdata;
            r_out_empty <= (r_depth == '0);
            r_out_err   <= r_err;
            r_out_last  <= (r_depth <= DEPTH_W'(1));
        end
    end

    // Status toward the controller
    always_comb begin
        o_status.full       = (r_depth >= DEPTH_W'(STACK_DEPTH));
        o_status.lt2        = (r_depth < DEPTH_W'(2));
        o_status.depth_zero = (r_depth == '0);
        o_status.last_entry = (r_depth <= DEPTH_W'(1));
        o_status.err_zero   = (r_err == ERR_NONE);
        o_status.div_op     = (r_op == OP_DIV) || (r_op == OP_REM);
        o_status.b_zero     = (r_b == '0);
        o_status.div_done   = w_div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out_value;
    assign o_stack_empty = r_out_empty;
    assign o_error_code  = r_out_err;
    assign o_last        = r_out_last;

endmodule

>>> rtl/core/pse_ctrl.sv
// ============================================================================
// Postfix stack evaluator controller
// Sequences pushes, operator reads and writes, divides and the end-of-
// expression drain of the stack.
// ============================================================================
module pse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    output logic               o_in_ready,
    input  pse_pkg::t_status   i_status,
    output pse_pkg::t_cmd      o_cmd
);
    import pse_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_opcode == OPC_APPLY) && !i_status.lt2) begin
                        n_state = S_RD_B;
                    end else if (i_opcode == OPC_END) begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_RD_B:   n_state = S_RD_A;
            S_RD_A:   n_state = S_LOAD_A;
            S_LOAD_A: n_state = S_EXEC;
            S_EXEC: begin
                if (i_status.div_op && !i_status.b_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:   n_state = S_IDLE;
            S_EMIT_RD: n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_entry ? S_IDLE : S_EMIT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cap_op = w_accept;
                if (w_accept && (i_opcode == OPC_PUSH)) begin
                    if (i_status.full) begin
                        o_cmd.flag_en   = 1'b1;
                        o_cmd.flag_code = ERR_OVERFLOW;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
                if (w_accept && (i_opcode == OPC_APPLY) && i_status.lt2) begin
                    o_cmd.flag_en   = 1'b1;
                    o_cmd.flag_code = ERR_UNDERFLOW;
                end
            end
            S_RD_B: begin
                o_cmd.rd_en = 1'b1;
            end
            S_RD_A: begin
                o_cmd.cap_b     = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_second = 1'b1;
            end
            S_LOAD_A: begin
                o_cmd.cap_a = 1'b1;
            end
            S_EXEC: begin
                if (i_status.div_op && !i_status.b_zero) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.exec = 1'b1;
                end
                if (i_status.div_op && i_status.b_zero) begin
                    o_cmd.flag_en   = 1'b1;
                    o_cmd.flag_code = ERR_DIVZERO;
                end
            end
            S_DIV: begin
                o_cmd.div_cap = i_status.div_done;
            end
            S_WRITE: begin
                o_cmd.wr_res = 1'b1;
            end
            S_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_EMIT_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/postfix_stack_evaluator_top.sv
// ============================================================================
// Postfix stack evaluator, top level
// Evaluates reverse Polish expressions on a stack of signed 32-bit values
// and drains the stack top first at the end of each expression.
// ============================================================================
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: operand; tuser: opcode, operator
//  m_axis   | out       | tdata: value; tuser: stack_empty, error_code;
//           |           | tlast: last
//
// A push is taken in the idle state. An operator reads both operands,
// runs the ALU, or the one-bit-per-cycle divider for divide and remainder,
// and writes the result back. An end item emits each entry (an empty stack
// counts as one entry), waiting while m_axis_tready stays low; a finished
// result waits in the output register while new items are taken.
// Synchronous active-low reset clears the depth, the error code and the
// controller; the stack memory itself is not cleared.
//
module postfix_stack_evaluator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic signed [pse_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] operand
    input  logic [pse_pkg::IN_USER_W-1:0]        s_axis_tuser,   // [1:0] opcode, [4:2] operator
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic signed [pse_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] value
    output logic [pse_pkg::OUT_USER_W-1:0]       m_axis_tuser,   // [0] stack_empty, [2:1] error_code
    output logic                                 m_axis_tlast
);
    import pse_pkg::*;

    `include "postfix_stack_evaluator_top_macros.svh"

    t_cmd              w_cmd;
    t_status           w_status;
    logic [DATA_W-1:0] w_value;
    logic              w_empty;
    logic [1:0]        w_err;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser[1:0]),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pse_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_operand     (s_axis_tdata),
        .i_operator    (s_axis_tuser[4:2]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_value       (w_value),
        .o_stack_empty (w_empty),
        .o_error_code  (w_err),
        .o_last        (m_axis_tlast)
    );

    // Pack the result
    assign m_axis_tdata = w_value;
    assign m_axis_tuser = {w_err, w_empty};

    // Checks
    `PSE_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_cmd.out_load, w_status.out_free, "result loaded over a pending transfer")
    `PSE_ASSERT_NXT(a_end_blocks, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == OPC_END), !s_axis_tready, "input taken during drain")
    `PSE_ASSERT_NXT(a_drain_clears, i_clk, i_rst_n, w_cmd.out_load && w_status.last_entry, w_status.depth_zero && w_status.err_zero, "stack not cleared after final result")
    `PSE_ASSERT_IMP(a_one_writer, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.push, w_cmd.wr_res, w_cmd.out_load}), "conflicting stack updates")

endmodule
